// ===== rtl/mexp_pkg.sv =====
// ---------------------------------------------------------------------------
// Modular exponentiation package
// Shared widths and the word type that moves along the multiplier cell row.
// ---------------------------------------------------------------------------
package mexp_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int EXP_WIDTH   = 16;
    localparam int CNT_W       = $clog2(EXP_WIDTH + 1);
    localparam int IN_W        = 2 * VALUE_WIDTH + EXP_WIDTH;
    localparam int IN_BYTES_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = ((VALUE_WIDTH + 7) / 8) * 8;

    // One modular multiply in flight: acc accumulates a*b mod n, b shifts out MSB first.
    typedef struct packed {
        logic                   valid;
        logic [VALUE_WIDTH-1:0] acc;
        logic [VALUE_WIDTH-1:0] a;
        logic [VALUE_WIDTH-1:0] b;
        logic [VALUE_WIDTH-1:0] n;
    } mm_word_t;

endpackage

// ===== rtl/modular_exponentiation.sv =====
// ---------------------------------------------------------------------------
// Modular exponentiation
// Left-to-right square and multiply over a row of modular multiply cells.
// ---------------------------------------------------------------------------
// Input words carry base, exponent and modulus; each gives one output word
// with base^exponent mod modulus in tdata and the zero-modulus flag in tuser.
// One word is worked on at a time: s_tready is high only while idle.
// Every modular multiply runs through a row of VALUE_WIDTH cells, one cell
// per multiplier bit. An item costs one multiply to reduce the base, then
// up to EXP_WIDTH bit steps, each a squaring plus a multiply for a one bit,
// plus a scan step for each leading zero of the exponent. The worst case is
// an all-ones exponent, with 33 multiplies. A zero modulus or zero exponent
// skips the multiplies and goes straight to the done state.
// The result sits in an output register; while the receiver stalls it holds,
// and the next word may be accepted, though its result waits until the held
// one is taken. Reset clears all control state; no word is in flight after.
// ---------------------------------------------------------------------------
module modular_exponentiation
    import mexp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_BYTES_W-1:0] s_tdata,   // base, exponent, modulus
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // power_mod
    output logic                  m_tuser    // bad_modulus
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_RED, ST_RWAIT, ST_SCAN, ST_SQ, ST_SWAIT, ST_MUL, ST_MWAIT, ST_DONE
    } state_t;

    state_t                 state_reg;
    logic [VALUE_WIDTH-1:0] n_reg;
    logic [VALUE_WIDTH-1:0] base_reg;
    logic [VALUE_WIDTH-1:0] x_reg;
    logic [VALUE_WIDTH-1:0] z_reg;
    logic [EXP_WIDTH-1:0]   e_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [VALUE_WIDTH-1:0] res_reg;
    logic                   bad_reg;
    logic                   out_valid_reg;
    logic [VALUE_WIDTH-1:0] out_data_reg;
    logic                   out_bad_reg;

    logic [VALUE_WIDTH-1:0] in_base;
    logic [EXP_WIDTH-1:0]   in_exp;
    logic [VALUE_WIDTH-1:0] in_n;
    logic [VALUE_WIDTH-1:0] one_mod;
    mm_word_t               issue_word;
    mm_word_t               chain [0:VALUE_WIDTH];

    assign in_base = s_tdata[VALUE_WIDTH-1:0];
    assign in_exp  = s_tdata[VALUE_WIDTH+EXP_WIDTH-1:VALUE_WIDTH];
    assign in_n    = s_tdata[2*VALUE_WIDTH+EXP_WIDTH-1:VALUE_WIDTH+EXP_WIDTH];
    assign one_mod = (n_reg == VALUE_WIDTH'(1)) ? '0 : VALUE_WIDTH'(1);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_data_reg);
    assign m_tuser  = out_bad_reg;

    always_comb
    begin
        issue_word       = '0;
        issue_word.n     = n_reg;
        issue_word.valid = 1'b0;
        case (state_reg)
            ST_RED:
            begin
                issue_word.valid = 1'b1;
                issue_word.a     = one_mod;
                issue_word.b     = base_reg;
            end
            ST_SQ:
            begin
                issue_word.valid = 1'b1;
                issue_word.a     = z_reg;
                issue_word.b     = z_reg;
            end
            ST_MUL:
            begin
                issue_word.valid = 1'b1;
                issue_word.a     = z_reg;
                issue_word.b     = x_reg;
            end
            default:
            begin
                issue_word.valid = 1'b0;
            end
        endcase
    end

    assign chain[0] = issue_word;

    for (genvar i = 0; i < VALUE_WIDTH; i++)
    begin : g_cell
        mexp_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .din  (chain[i]),
            .dout (chain[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_bad_reg   <= 1'b0;
            n_reg         <= '0;
            base_reg      <= '0;
            x_reg         <= '0;
            z_reg         <= '0;
            e_reg         <= '0;
            cnt_reg       <= '0;
            res_reg       <= '0;
            bad_reg       <= 1'b0;
        end
        else
        begin
            // In ST_DONE the output register is reloaded below instead.
            if (out_valid_reg && m_tready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        n_reg    <= in_n;
                        base_reg <= in_base;
                        e_reg    <= in_exp;
                        cnt_reg  <= CNT_W'(EXP_WIDTH);
                        bad_reg  <= 1'b0;
                        if (in_n == '0)
                        begin
                            res_reg   <= '0;
                            bad_reg   <= 1'b1;
                            state_reg <= ST_DONE;
                        end
                        else if (in_exp == '0)
                        begin
                            res_reg   <= VALUE_WIDTH'(1);
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_RED;
                        end
                    end
                end
                ST_RED:
                begin
                    state_reg <= ST_RWAIT;
                end
                ST_RWAIT:
                begin
                    if (chain[VALUE_WIDTH].valid)
                    begin
                        x_reg     <= chain[VALUE_WIDTH].acc;
                        z_reg     <= one_mod;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    // Skip leading zeros; the exponent is known to be nonzero.
                    if (e_reg[EXP_WIDTH-1])
                    begin
                        state_reg <= ST_SQ;
                    end
                    else
                    begin
                        e_reg   <= {e_reg[EXP_WIDTH-2:0], 1'b0};
                        cnt_reg <= cnt_reg - CNT_W'(1);
                    end
                end
                ST_SQ:
                begin
                    state_reg <= ST_SWAIT;
                end
                ST_SWAIT:
                begin
                    if (chain[VALUE_WIDTH].valid)
                    begin
                        z_reg <= chain[VALUE_WIDTH].acc;
                        if (e_reg[EXP_WIDTH-1])
                        begin
                            state_reg <= ST_MUL;
                        end
                        else if (cnt_reg == CNT_W'(1))
                        begin
                            res_reg   <= chain[VALUE_WIDTH].acc;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            e_reg     <= {e_reg[EXP_WIDTH-2:0], 1'b0};
                            cnt_reg   <= cnt_reg - CNT_W'(1);
                            state_reg <= ST_SQ;
                        end
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_MWAIT;
                end
                ST_MWAIT:
                begin
                    if (chain[VALUE_WIDTH].valid)
                    begin
                        z_reg <= chain[VALUE_WIDTH].acc;
                        if (cnt_reg == CNT_W'(1))
                        begin
                            res_reg   <= chain[VALUE_WIDTH].acc;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            e_reg     <= {e_reg[EXP_WIDTH-2:0], 1'b0};
                            cnt_reg   <= cnt_reg - CNT_W'(1);
                            state_reg <= ST_SQ;
                        end
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= res_reg;
                        out_bad_reg   <= bad_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/mexp_cell.sv =====
// ---------------------------------------------------------------------------
// Modular multiply cell
// One step of interleaved multiplication: acc = 2*acc + bit*a, reduced mod n.
// ---------------------------------------------------------------------------
module mexp_cell
    import mexp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mm_word_t din,
    output mm_word_t dout
);

    logic [VALUE_WIDTH:0]   dbl;
    logic [VALUE_WIDTH-1:0] red1;
    logic [VALUE_WIDTH:0]   sum;
    logic [VALUE_WIDTH-1:0] red2;
    logic                   valid_reg;
    mm_word_t               data_reg;
    mm_word_t               data_next;

    always_comb
    begin
        dbl  = {din.acc, 1'b0};
        red1 = (dbl >= {1'b0, din.n}) ? VALUE_WIDTH'(dbl - {1'b0, din.n})
                                      : dbl[VALUE_WIDTH-1:0];
        sum  = {1'b0, red1} + (din.b[VALUE_WIDTH-1] ? {1'b0, din.a}
                                                    : {(VALUE_WIDTH+1){1'b0}});
        red2 = (sum >= {1'b0, din.n}) ? VALUE_WIDTH'(sum - {1'b0, din.n})
                                      : sum[VALUE_WIDTH-1:0];
        data_next       = din;
        data_next.acc   = red2;
        data_next.b     = {din.b[VALUE_WIDTH-2:0], 1'b0};
        data_next.valid = din.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= data_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        dout       = data_reg;
        dout.valid = valid_reg;
    end

endmodule

// ===== rtl/mexp_checker.sv =====
// ---------------------------------------------------------------------------
// Modular exponentiation checker
// Port-level checks on the stream channels, bound to the top level.
// ---------------------------------------------------------------------------
module mexp_checker
    import mexp_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_W-1:0]      m_tdata,
    input logic                  m_tuser
);

    // A zero-modulus word always carries a zero result.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("bad_modulus word with nonzero result");

    // One word at a time: after an accept the input side is busy.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted twice in a row");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("output word dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser)))
        else $error("output word changed while stalled");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);

// ===== verif/tb.sv =====
// ---------------------------------------------------------------------------
// Modular exponentiation testbench
// Drives base, exponent and modulus words through the block, predicts each
// power_mod and zero-modulus flag with its own square-and-multiply, and
// compares every output word with the oldest prediction.
// ---------------------------------------------------------------------------
module tb
    import mexp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [VALUE_WIDTH-1:0] power_mod;
        logic                   bad_modulus;
    } power_result_t;

    typedef struct {
        logic [VALUE_WIDTH-1:0] base;
        logic [EXP_WIDTH-1:0]   exponent;
        logic [VALUE_WIDTH-1:0] modulus;
        logic                   typed;
        logic [VALUE_WIDTH-1:0] power_mod;
        logic                   bad_modulus;
    } vector_t;

    localparam int  RANDOM_WORDS = 450;
    localparam int  DRAIN_CYCLES = 1200;
    localparam longint CYCLE_LIMIT = 64'd4_000_000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_BYTES_W-1:0] s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_W-1:0]      m_tdata;
    logic                  m_tuser;

    power_result_t pending_powers[$];
    int            error_count;
    longint        cycle_count;
    logic          stimulus_done;
    logic          long_hold;

    modular_exponentiation DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Exact modular product: 64-bit intermediate is wide enough for 32-bit values.
    function automatic logic [VALUE_WIDTH-1:0] mod_product(
        input logic [VALUE_WIDTH-1:0] a,
        input logic [VALUE_WIDTH-1:0] b,
        input logic [VALUE_WIDTH-1:0] n
    );
        logic [2*VALUE_WIDTH-1:0] prod;
        prod = {{VALUE_WIDTH{1'b0}}, a} * {{VALUE_WIDTH{1'b0}}, b};
        return VALUE_WIDTH'(prod % {{VALUE_WIDTH{1'b0}}, n});
    endfunction

    function automatic power_result_t predict_power(
        input logic [VALUE_WIDTH-1:0] base,
        input logic [EXP_WIDTH-1:0]   exponent,
        input logic [VALUE_WIDTH-1:0] modulus
    );
        power_result_t          res;
        logic [VALUE_WIDTH-1:0] acc;
        logic [VALUE_WIDTH-1:0] reduced;
        logic                   started;
        res.bad_modulus = 1'b0;
        if (modulus == '0)
        begin
            res.power_mod   = '0;
            res.bad_modulus = 1'b1;
            return res;
        end
        // Exponent zero gives 1 even for modulus 1, since no step reduces it.
        acc     = VALUE_WIDTH'(1);
        started = 1'b0;
        reduced = base % modulus;
        for (int i = EXP_WIDTH - 1; i >= 0; i--)
        begin
            if (exponent[i])
                started = 1'b1;
            if (started)
            begin
                acc = mod_product(acc % modulus, acc % modulus, modulus);
                if (exponent[i])
                    acc = mod_product(acc, reduced, modulus);
            end
        end
        res.power_mod = acc;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    task automatic send_word(input vector_t v);
        power_result_t exp_res;
        exp_res = predict_power(v.base, v.exponent, v.modulus);
        if (v.typed && (exp_res.power_mod != v.power_mod
                        || exp_res.bad_modulus != v.bad_modulus))
            report_mismatch($sformatf("table row disagrees with prediction for %h^%h mod %h",
                                      v.base, v.exponent, v.modulus));
        if (v.typed)
        begin
            exp_res.power_mod   = v.power_mod;
            exp_res.bad_modulus = v.bad_modulus;
        end
        s_tdata  <= IN_BYTES_W'({v.modulus, v.exponent, v.base});
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        pending_powers.push_back(exp_res);
        @(negedge clk);
    endtask

    function automatic vector_t row(
        input logic [VALUE_WIDTH-1:0] base,
        input logic [EXP_WIDTH-1:0]   exponent,
        input logic [VALUE_WIDTH-1:0] modulus,
        input logic                   typed,
        input logic [VALUE_WIDTH-1:0] power_mod,
        input logic                   bad_modulus
    );
        vector_t v;
        v.base        = base;
        v.exponent    = exponent;
        v.modulus     = modulus;
        v.typed       = typed;
        v.power_mod   = power_mod;
        v.bad_modulus = bad_modulus;
        return v;
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] random_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 16);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 16);
            2: return $urandom_range(0, 65535);
            default: return $urandom;
        endcase
    endfunction

    // Stimulus
    initial
    begin
        vector_t directed[$];
        vector_t v;
        int      burst;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        stimulus_done = 1'b0;
        error_count   = 0;
        directed = '{
            row(32'd5,          16'd0,      32'd1,          1, 32'd1, 0),
            row(32'd0,          16'd0,      32'd0,          1, 32'd0, 1),
            row(32'hFFFF_FFFF,  16'hFFFF,   32'd0,          1, 32'd0, 1),
            row(32'd0,          16'd0,      32'd7,          1, 32'd1, 0),
            row(32'd0,          16'd5,      32'd7,          1, 32'd0, 0),
            row(32'd2,          16'd10,     32'd1000,       1, 32'd24, 0),
            row(32'd3,          16'd1,      32'd1,          1, 32'd0, 0),
            row(32'hFFFF_FFFF,  16'd1,      32'hFFFF_FFFF,  1, 32'd0, 0),
            row(32'hFFFF_FFFE,  16'd2,      32'hFFFF_FFFF,  1, 32'd1, 0),
            row(32'd12,         16'd1,      32'd5,          1, 32'd2, 0),
            row(32'hFFFF_FFFF,  16'hFFFF,   32'hFFFF_FFFF,  0, 0, 0),
            row(32'hFFFF_FFFF,  16'hFFFF,   32'hFFFF_FFFB,  0, 0, 0),
            row(32'h8000_0000,  16'h8000,   32'hFFFF_FFF1,  0, 0, 0),
            row(32'h1234_5678,  16'h5555,   32'hAAAA_AAAB,  0, 0, 0),
            row(32'hEDCB_A987,  16'hAAAA,   32'h5555_5555,  0, 0, 0),
            row(32'd7,          16'hFFFF,   32'h8000_0000,  0, 0, 0),
            row(32'd3,          16'h0001,   32'd2,          0, 0, 0)
        };
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (directed[i])
            send_word(directed[i]);

        for (int n = 0; n < RANDOM_WORDS; )
        begin
            burst = $urandom_range(1, 8);
            for (int k = 0; k < burst && n < RANDOM_WORDS; k++, n++)
            begin
                v = row(random_value(), 16'($urandom), random_value(), 0, 0, 0);
                if ($urandom_range(0, 30) == 0)
                    v.modulus = '0;
                // Mostly short exponents keep the run quick; some use all bits.
                if ($urandom_range(0, 3) != 0)
                    v.exponent = v.exponent >> $urandom_range(4, 15);
                send_word(v);
            end
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(negedge clk);
        end
        stimulus_done <= 1'b1;
    end

    // Receiver stalls; once early on it holds off long enough to back up the input.
    initial
    begin
        int pattern;
        m_tready  = 1'b0;
        long_hold = 1'b0;
        @(posedge rst_n);
        repeat (30) @(negedge clk);
        long_hold = 1'b1;
        repeat (3000) @(negedge clk);
        long_hold = 1'b0;
        forever
        begin
            pattern = $urandom_range(0, 3);
            repeat ($urandom_range(20, 400))
            begin
                case (pattern)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    2: m_tready <= ($urandom_range(0, 7) == 0);
                    default: m_tready <= ($urandom_range(0, 9) != 0);
                endcase
                @(negedge clk);
                while (long_hold)
                    @(negedge clk);
            end
        end
    end

    always @(negedge clk)
        if (long_hold)
            m_tready <= 1'b0;

    // Output checking
    always @(posedge clk)
    begin
        power_result_t exp_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_powers.size() == 0)
                report_mismatch($sformatf("unexpected output word %h", m_tdata));
            else
            begin
                exp_res = pending_powers.pop_front();
                if (m_tdata[VALUE_WIDTH-1:0] !== exp_res.power_mod)
                    report_mismatch($sformatf("power_mod %h, expected %h",
                                              m_tdata[VALUE_WIDTH-1:0], exp_res.power_mod));
                if (m_tuser !== exp_res.bad_modulus)
                    report_mismatch($sformatf("bad_modulus %b, expected %b",
                                              m_tuser, exp_res.bad_modulus));
            end
        end
    end

    // End of run and timeout
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            if (stimulus_done && pending_powers.size() == 0)
            begin
                repeat (DRAIN_CYCLES) @(posedge clk);
                if (error_count == 0)
                    $display("CHECK OK");
                else
                    $display("CHECK FAILED");
                $finish;
            end
        end
    end

endmodule
